>>> rtl/core/set_assoc_cache_lru_tags_defines.svh
// assertion macros used by the cache tag store back end
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef SET_ASSOC_CACHE_LRU_TAGS_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_DEFINES_SVH
`ifndef ASSERT_OFF
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/sacl_pkg.sv
// shared types and constants of the set-associative cache tag store
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;

    localparam int ADDR_BITS       = 27;
    localparam int TOTAL_LINES_DEF = 512;
    localparam int MAX_WAYS_DEF    = 16;
    localparam int CFG_W           = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int WAY_W           = 4;

    localparam logic [CFG_W-1:0] WAYS_LOG2_RESET = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAYS_LOG2   = 1'b0,
        REG_WRITE_ALLOC = 1'b1
    } cfg_reg_e;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [ADDR_BITS-1:0] line_address;
    } sacl_in_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way_used;
        logic             allocated;
        logic             evicted;
    } sacl_out_t;

endpackage
`default_nettype wire

>>> rtl/core/set_assoc_cache_lru_tags.sv
// Tag store of a set-associative cache with true-LRU replacement: one result
// beat per access beat (hit, way used, allocated, evicted). The back end takes
// one access at a time: it reads the set's entries from the per-way banks in
// the idle state, then compares tags, updates the LRU ranks and writes back in
// the eval state, which waits while the result register is held. After reset
// a clearing pass over every bank address initializes the banks; no
// access is taken until it ends. Change ways_log2 only followed by reset.
// depends on sacl_pkg, sacl_front, sacl_queue, sacl_back
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_tags
    import sacl_pkg::*;
#(
    parameter int TOTAL_LINES = TOTAL_LINES_DEF,
    parameter int MAX_WAYS    = MAX_WAYS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sacl_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sacl_out_t                 m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int LOG2MAX = $clog2(MAX_WAYS);
    localparam int SET_W   = $clog2(TOTAL_LINES);
    localparam int TAG_W   = ADDR_BITS - $clog2(TOTAL_LINES / MAX_WAYS);
    localparam int QW      = 1 + SET_W + TAG_W;

    logic [CFG_W-1:0] ways_log2_reg;
    logic             write_alloc_reg;
    logic [CFG_W-1:0] eff_wl;

    logic             clearing, q_full, q_push, q_store, q_valid, q_pop;
    logic [SET_W-1:0] q_set;
    logic [TAG_W-1:0] q_tag;
    logic [QW-1:0]    q_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_log2_reg   <= WAYS_LOG2_RESET;
            write_alloc_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WAYS_LOG2:   ways_log2_reg   <= cfg_wdata;
                REG_WRITE_ALLOC: write_alloc_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // oversized associativity saturates
    assign eff_wl = (ways_log2_reg > CFG_W'(LOG2MAX)) ? CFG_W'(LOG2MAX) : ways_log2_reg;

    sacl_front #(
        .TOTAL_LINES(TOTAL_LINES),
        .MAX_WAYS   (MAX_WAYS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .eff_wl  (eff_wl),
        .clearing(clearing),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_store (q_store),
        .q_set   (q_set),
        .q_tag   (q_tag)
    );

    sacl_queue #(
        .WIDTH(QW),
        .DEPTH(2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_data ({q_store, q_set, q_tag}),
        .full    (q_full),
        .rd_valid(q_valid),
        .rd_en   (q_pop),
        .rd_data (q_rd)
    );

    sacl_back #(
        .TOTAL_LINES(TOTAL_LINES),
        .MAX_WAYS   (MAX_WAYS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_wl     (eff_wl),
        .write_alloc(write_alloc_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_store    (q_rd[QW-1]),
        .q_set      (q_rd[TAG_W +: SET_W]),
        .q_tag      (q_rd[TAG_W-1:0]),
        .clearing   (clearing),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

>>> rtl/core/sacl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sacl_front.sv
// front end: takes accesses and splits the line address into set and tag
// depends on sacl_pkg
`timescale 1ns / 1ps
`default_nettype none
module sacl_front
    import sacl_pkg::*;
#(
    parameter int TOTAL_LINES = TOTAL_LINES_DEF,
    parameter int MAX_WAYS    = MAX_WAYS_DEF
) (
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sacl_in_t             s_data,
    input  wire logic [CFG_W-1:0]     eff_wl,
    input  wire logic                 clearing,
    input  wire logic                 q_full,
    output logic                      q_push,
    output logic                      q_store,
    output logic [$clog2(TOTAL_LINES)-1:0] q_set,
    output logic [ADDR_BITS-$clog2(TOTAL_LINES/MAX_WAYS)-1:0] q_tag
);

    localparam int SET_W = $clog2(TOTAL_LINES);
    localparam int TAG_W = ADDR_BITS - $clog2(TOTAL_LINES / MAX_WAYS);
    localparam int SB_W  = $clog2(SET_W + 1);

    logic [SB_W-1:0]      sbits;
    logic [SET_W-1:0]     set_mask;
    logic [ADDR_BITS-1:0] tag_full;

    assign s_ready = !clearing && !q_full;
    assign q_push  = s_valid && s_ready;
    assign q_store = (s_data.operation == OP_STORE);

    // fewer set bits as the ways grow
    assign sbits    = SB_W'(SET_W) - SB_W'(eff_wl);
    assign set_mask = ~({SET_W{1'b1}} << sbits);
    assign q_set    = s_data.line_address[SET_W-1:0] & set_mask;
    assign tag_full = s_data.line_address >> sbits;
    assign q_tag    = tag_full[TAG_W-1:0];

endmodule
`default_nettype wire

>>> rtl/core/sacl_queue.sv
// short fifo between the decode front end and the tag update back end
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sacl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (wr_en) begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd_en) begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sacl_back.sv
// back end: way banks, tag compare, true-lru update and result register
// depends on sacl_pkg, sacl_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lru_tags_defines.svh"
module sacl_back
    import sacl_pkg::*;
#(
    parameter int TOTAL_LINES = TOTAL_LINES_DEF,
    parameter int MAX_WAYS    = MAX_WAYS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [CFG_W-1:0]     eff_wl,
    input  wire logic                 write_alloc,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire logic                 q_store,
    input  wire logic [$clog2(TOTAL_LINES)-1:0] q_set,
    input  wire logic [ADDR_BITS-$clog2(TOTAL_LINES/MAX_WAYS)-1:0] q_tag,
    output logic                      clearing,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sacl_out_t                 m_data
);

    localparam int LOG2MAX = $clog2(MAX_WAYS);
    localparam int BANK_N  = MAX_WAYS;
    localparam int BANK_D  = TOTAL_LINES / MAX_WAYS;
    localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int SET_W   = $clog2(TOTAL_LINES);
    localparam int TAG_W   = ADDR_BITS - $clog2(BANK_D);
    localparam int RANK_W  = (LOG2MAX > 0) ? LOG2MAX : 1;
    localparam int BI_W    = RANK_W;
    localparam int ENT_W   = 1 + TAG_W + RANK_W;
    localparam int RSETS   = (MAX_WAYS > 1) ? TOTAL_LINES / 2 : TOTAL_LINES;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t              state_reg;
    logic [BANK_AW-1:0]  clr_cnt_reg;
    logic                m_valid_reg;
    sacl_out_t           m_data_reg;
    logic                item_store_reg;
    logic [SET_W-1:0]    item_set_reg;
    logic [TAG_W-1:0]    item_tag_reg;

    logic [ENT_W-1:0]    rd_ent  [BANK_N];
    logic [ENT_W-1:0]    upd_ent [BANK_N];
    logic                ent_vld [BANK_N];
    logic [TAG_W-1:0]    ent_tag [BANK_N];
    logic [RANK_W-1:0]   ent_rank[BANK_N];

    logic [BANK_N-1:0]   part, match, inval, vic, sel_oh;
    logic [CFG_W-1:0]    sh;
    logic [BI_W-1:0]     set_hi, hi_mask, sel_idx;
    logic [RANK_W-1:0]   old_rank, ways_m1;
    logic                hit, any_inval, alloc, do_write, ev_fire;

    function automatic logic [BANK_N-1:0] lowest_one(input logic [BANK_N-1:0] v);
        return v & (~v + BANK_N'(1));
    endfunction

    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign ev_fire  = (state_reg == ST_EVAL) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // way w of a set sits in bank set_hi + w * (banks per way)
    assign sh      = CFG_W'(LOG2MAX) - eff_wl;
    assign set_hi  = BI_W'(item_set_reg >> BANK_AW);
    assign hi_mask = ~({BI_W{1'b1}} << sh);
    assign ways_m1 = ~({RANK_W{1'b1}} << eff_wl);

    always_comb begin
        for (int b = 0; b < BANK_N; b++) begin
            ent_vld[b]  = rd_ent[b][ENT_W-1];
            ent_tag[b]  = rd_ent[b][ENT_W-2 -: TAG_W];
            ent_rank[b] = rd_ent[b][RANK_W-1:0];
            part[b]     = ((BI_W'(b) & hi_mask) == set_hi);
            match[b]    = part[b] && ent_vld[b] && (ent_tag[b] == item_tag_reg);
            inval[b]    = part[b] && !ent_vld[b];
        end
    end

    // lru victim: highest rank, ties to the lowest way
    always_comb begin
        for (int b = 0; b < BANK_N; b++) begin
            vic[b] = part[b];
            for (int c = 0; c < BANK_N; c++) begin
                if (part[c] && (c != b)) begin
                    if ((ent_rank[c] > ent_rank[b]) ||
                        ((ent_rank[c] == ent_rank[b]) && (c < b))) begin
                        vic[b] = 1'b0;
                    end
                end
            end
        end
    end

    assign hit       = |match;
    assign any_inval = |inval;
    assign alloc     = !hit && !(item_store_reg && !write_alloc);
    assign do_write  = hit || alloc;
    assign sel_oh    = hit ? lowest_one(match) :
                       (any_inval ? lowest_one(inval) : lowest_one(vic));

    always_comb begin
        sel_idx  = '0;
        old_rank = '0;
        for (int b = 0; b < BANK_N; b++) begin
            if (sel_oh[b]) begin
                sel_idx  = sel_idx | BI_W'(b);
                old_rank = old_rank | ent_rank[b];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < BANK_N; b++) begin
            upd_ent[b] = rd_ent[b];
            if (sel_oh[b]) begin
                upd_ent[b] = {1'b1, (hit ? ent_tag[b] : item_tag_reg), {RANK_W{1'b0}}};
            end else if ((ent_rank[b] <= old_rank) && (ent_rank[b] < ways_m1)) begin
                upd_ent[b][RANK_W-1:0] = ent_rank[b] + 1'b1;
            end
        end
    end

    for (genvar gb = 0; gb < BANK_N; gb++) begin : g_bank
        localparam int RST_RANK = (gb * BANK_D) / RSETS;
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [ENT_W-1:0]   wdata;

        assign we    = clearing || (ev_fire && do_write && part[gb]);
        assign waddr = clearing ? clr_cnt_reg : item_set_reg[BANK_AW-1:0];
        assign wdata = clearing ? {1'b0, {TAG_W{1'b0}}, RANK_W'(RST_RANK)} : upd_ent[gb];

        sacl_ram #(
            .WIDTH(ENT_W),
            .DEPTH(BANK_D)
        ) u_ram (
            .aclk (aclk),
            .we   (we),
            .waddr(waddr),
            .wdata(wdata),
            .re   (q_pop),
            .raddr(q_set[BANK_AW-1:0]),
            .rdata(rd_ent[gb])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BANK_AW'(BANK_D - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (ev_fire) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (ev_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_store_reg <= q_store;
            item_set_reg   <= q_set;
            item_tag_reg   <= q_tag;
        end
        if (ev_fire) begin
            m_data_reg.hit       <= hit;
            m_data_reg.way_used  <= do_write ? WAY_W'(sel_idx >> sh) : '0;
            m_data_reg.allocated <= alloc;
            m_data_reg.evicted   <= alloc && !any_inval;
        end
    end

    `SACL_ASSERT(a_no_pop_clear, aclk, aresetn, clearing |-> !q_pop, "pop during clearing pass")
    `SACL_ASSERT_NEXT(a_result_load, aclk, aresetn, ev_fire, m_valid_reg, "result not loaded")
    `SACL_ASSERT(a_one_way, aclk, aresetn, (ev_fire && do_write) |-> $onehot(sel_oh), "way not unique")

endmodule
`default_nettype wire
